### hdl/supercap_power_charge_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Supercap charge controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SUPERCAP_POWER_CHARGE_CONTROLLER_UNIT_MACROS_SVH
`define SUPERCAP_POWER_CHARGE_CONTROLLER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define SCPC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SCPC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SCPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/scpc_pkg.sv
// ----------------------------------------------------------------------------
// Supercap charge controller package
// Shared types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scpc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_TARGET_POWER = 3'd0;
  localparam logic [2:0] CFG_MAX_VOLTAGE  = 3'd1;
  localparam logic [2:0] CFG_MIN_VOLTAGE  = 3'd2;
  localparam logic [2:0] CFG_LINK_TIMEOUT = 3'd3;
  localparam logic [2:0] CFG_STEADY_TIME  = 3'd4;

  // register reset values
  localparam logic [15:0] TARGET_POWER_RST = 16'd1200;
  localparam logic [14:0] MAX_VOLTAGE_RST  = 15'd23800;
  localparam logic [14:0] MIN_VOLTAGE_RST  = 15'd13000;
  localparam logic [7:0]  LINK_TIMEOUT_RST = 8'd250;
  localparam logic [15:0] STEADY_TIME_RST  = 16'd200;

  // control constants, integral in 1/1600 units
  localparam logic signed [23:0] INTEG_INIT  = 24'sd8000;
  localparam logic signed [24:0] INTEG_LIMIT = 25'sd3200000;
  localparam logic [15:0] LOW_ENERGY_PID     = 16'd960;
  localparam logic [15:0] LOW_ENERGY_CTRL    = 16'd800;
  localparam logic [15:0] DISCHARGE_MARGIN   = 16'd1500;
  localparam logic [8:0]  LINK_SAT           = 9'd256;

  // steady-motion detector stages
  localparam logic [1:0] STEADY_IDLE  = 2'd0;
  localparam logic [1:0] STEADY_TIMED = 2'd1;
  localparam logic [1:0] STEADY_DONE  = 2'd2;

  // dac scaling: code = base + min(sum / 9600, 235), 9600 = 128 * 75
  localparam logic [10:0] DAC_BASE = 11'd1270;
  localparam logic [10:0] DAC_MAX  = 11'd1505;
  // largest sum that still maps below the span limit plus one step
  localparam logic signed [28:0] SUM_CLIP = 29'sd2265599;
  // ceil(2^22 / 75), exact for quotients of 15-bit values
  localparam logic [15:0] DAC_RECIP = 16'd55925;
  localparam int unsigned DAC_SHIFT = 22;

  // configuration register set
  typedef struct packed {
    logic [15:0] target_power;
    logic [14:0] max_voltage_mv;
    logic [14:0] min_voltage_mv;
    logic [7:0]  link_timeout;
    logic [15:0] steady_time;
  } scpc_cfg_t;

  // one input item
  typedef struct packed {
    logic        starting;
    logic        link_ok;
    logic        remote_mode;
    logic        shift_pressed;
    logic [15:0] chassis_power;
    logic [15:0] remain_energy;
    logic signed [15:0] speed_target;
    logic [14:0] cap_voltage_mv;
    logic [31:0] tick_time;
  } scpc_in_t;

  // control result handed to the dac scaling stage
  typedef struct packed {
    logic        dac_on;
    logic [14:0] quo_in;
    logic        charge_switch;
    logic        discharge_switch;
    logic        discharge_allowed;
    logic        steady_motion;
  } scpc_res_t;

endpackage

### hdl/scpc_ctrl.sv
// ----------------------------------------------------------------------------
// Supercap charge controller state update
// Flags, link counter, steady detector and PI integral for one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "supercap_power_charge_controller_unit_macros.svh"

module scpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  scpc_pkg::scpc_cfg_t cfg,
  input  scpc_pkg::scpc_in_t  item,
  output scpc_pkg::scpc_res_t res
);

  // state
  logic        charge_flag, charge_flag_next;
  logic        discharge_flag, discharge_flag_next;
  logic [8:0]  link_cnt, link_cnt_next;
  logic signed [23:0] integ, integ_next;
  logic [1:0]  steady_stage, steady_stage_next;
  logic [31:0] steady_start, steady_start_next;
  logic        steady_latched, steady_latched_next;
  logic signed [15:0] prev_speed, prev_speed_next;

  // working values
  logic        charge_mid;
  logic        link_in_time;
  logic        same;
  logic        low_gain;
  logic [31:0] elapsed;
  logic signed [16:0] err;
  logic signed [21:0] ierr;
  logic signed [24:0] integ_sum;
  logic signed [23:0] integ_base, integ_clamped;
  logic signed [28:0] p_term, sum;
  logic [21:0] clip_val;

  // tick update
  always_comb begin
    charge_flag_next    = charge_flag;
    discharge_flag_next = discharge_flag;
    link_cnt_next       = link_cnt;
    integ_next          = integ;
    steady_stage_next   = steady_stage;
    steady_start_next   = steady_start;
    steady_latched_next = steady_latched;
    prev_speed_next     = prev_speed;
    integ_base          = integ;
    link_in_time        = 1'b0;
    charge_mid          = charge_flag;
    sum                 = '0;
    low_gain            = 1'b0;

    // start-up and link check
    if (item.starting) begin
      integ_base          = scpc_pkg::INTEG_INIT;
      discharge_flag_next = 1'b0;
    end else begin
      if (!item.link_ok) begin
        if (link_cnt < scpc_pkg::LINK_SAT) link_cnt_next = link_cnt + 9'd1;
      end else begin
        link_cnt_next = '0;
      end
      link_in_time        = link_cnt_next <= {1'b0, cfg.link_timeout};
      charge_mid          = link_in_time;
      discharge_flag_next = link_in_time && !item.remote_mode && item.shift_pressed &&
                            (item.cap_voltage_mv > cfg.min_voltage_mv);
    end
    integ_next = integ_base;

    same    = (item.speed_target != 16'sd0) && (item.speed_target == prev_speed);
    elapsed = item.tick_time - steady_start;

    // error terms
    err       = $signed({1'b0, cfg.target_power}) - $signed({1'b0, item.chassis_power});
    integ_sum = '0;
    integ_clamped = integ_base;
    ierr      = '0;
    p_term    = '0;

    // steady detector and pi loop, only while charging
    if (charge_mid) begin
      if (same && steady_stage == scpc_pkg::STEADY_IDLE) begin
        steady_start_next = item.tick_time;
        steady_stage_next = scpc_pkg::STEADY_TIMED;
      end else if (same && steady_stage == scpc_pkg::STEADY_TIMED) begin
        if (elapsed > {16'd0, cfg.steady_time}) steady_stage_next = scpc_pkg::STEADY_DONE;
      end else if (same && steady_stage == scpc_pkg::STEADY_DONE) begin
        steady_latched_next = 1'b1;
      end else begin
        steady_stage_next   = scpc_pkg::STEADY_IDLE;
        steady_latched_next = 1'b0;
      end
      prev_speed_next = item.speed_target;

      low_gain = !item.shift_pressed && (item.speed_target != 16'sd0) && steady_latched_next;

      // integral grows by err * I * 2, clamped
      ierr      = low_gain ? (22'(err) <<< 4) : (22'(err) * 22'sd20);
      integ_sum = 25'(integ_base) + 25'(ierr);
      if (integ_sum > scpc_pkg::INTEG_LIMIT)
        integ_clamped = 24'(scpc_pkg::INTEG_LIMIT);
      else if (integ_sum < -scpc_pkg::INTEG_LIMIT)
        integ_clamped = 24'(-scpc_pkg::INTEG_LIMIT);
      else
        integ_clamped = 24'(integ_sum);
      integ_next = integ_clamped;

      p_term = 29'(err) * (low_gain ? 29'sd1100 : 29'sd1500);

      if (item.remain_energy < scpc_pkg::LOW_ENERGY_PID) begin
        integ_next = '0;
        charge_mid = 1'b0;
        sum        = '0;
      end else begin
        sum = p_term + 29'(integ_clamped);
      end
    end

    charge_flag_next = charge_mid;
    if (item.remain_energy < scpc_pkg::LOW_ENERGY_CTRL) charge_flag_next = 1'b0;
  end

  // clip the pi sum to the range that the dac span covers
  always_comb begin
    if (sum <= 29'sd0)
      clip_val = '0;
    else if (sum > scpc_pkg::SUM_CLIP)
      clip_val = 22'(scpc_pkg::SUM_CLIP);
    else
      clip_val = 22'(sum);
  end

  // result of this tick
  always_comb begin
    res.dac_on            = (charge_flag || !item.starting) ?
                            (item.starting ? charge_flag : link_in_time) : 1'b0;
    res.quo_in            = clip_val[21:7];
    res.charge_switch     = charge_flag_next && (item.cap_voltage_mv < cfg.max_voltage_mv);
    res.discharge_switch  = discharge_flag_next;
    res.discharge_allowed = item.shift_pressed && discharge_flag_next &&
                            ({1'b0, item.cap_voltage_mv} >
                             ({1'b0, cfg.min_voltage_mv} + scpc_pkg::DISCHARGE_MARGIN));
    res.steady_motion     = steady_latched_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      charge_flag    <= 1'b0;
      discharge_flag <= 1'b0;
      link_cnt       <= '0;
      integ          <= scpc_pkg::INTEG_INIT;
      steady_stage   <= scpc_pkg::STEADY_IDLE;
      steady_start   <= '0;
      steady_latched <= 1'b0;
      prev_speed     <= '0;
    end else if (en) begin
      charge_flag    <= charge_flag_next;
      discharge_flag <= discharge_flag_next;
      link_cnt       <= link_cnt_next;
      integ          <= integ_next;
      steady_stage   <= steady_stage_next;
      steady_start   <= steady_start_next;
      steady_latched <= steady_latched_next;
      prev_speed     <= prev_speed_next;
    end
  end

  `SCPC_ASSERT_ALWAYS(a_link_sat, link_cnt <= scpc_pkg::LINK_SAT, "link counter past saturation")
  `SCPC_ASSERT_IMPLY(a_latch_stage, steady_latched, steady_stage == scpc_pkg::STEADY_DONE, "steady latch without final stage")
  `SCPC_ASSERT_ALWAYS(a_integ_range, (integ <= 24'sd3200000) && (integ >= -24'sd3200000), "integral outside clamp")

endmodule

### hdl/supercap_power_charge_controller_unit.sv
// ----------------------------------------------------------------------------
// Supercap power charge controller
// Per control tick: charge and discharge flags, PI power loop and dac code.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one control tick per beat (flags, power, energy, speed target,
//   capacitor voltage, timer). m_* returns one result beat per tick: dac code,
//   charge and discharge switches, discharge-allowed and steady-motion flags.
//   cfg_* writes a register by index (target power, max and min voltage, link
//   timeout, steady time); cfg_ready is always high, write only while idle.
// Pipeline and throughput:
//   three stages: input register, state update with the pi sum register, and
//   the dac scaling multiply into the output register. One beat is taken every
//   cycle while m_tready stays high.
// Reset:
//   rst clears the stage valid bits and sets all config registers and controller state to
//   their defaults (integral 8000, flags and counters zero).
// Stall:
//   when m_tready is low the result holds; the earlier stages keep filling
//   until each holds a beat, and only then does s_tready drop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "supercap_power_charge_controller_unit_macros.svh"

module supercap_power_charge_controller_unit (
  input  logic         clk,
  input  logic         rst,
  // config write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // input ticks
  input  logic         s_tvalid,
  output logic         s_tready,
  // starting, link_ok, remote_mode, shift_pressed, chassis_power[16],
  // remain_energy[16], speed_target[16], cap_voltage_mv[15], tick_time[32], pad
  input  logic [103:0] s_tdata,
  // results
  output logic         m_tvalid,
  input  logic         m_tready,
  // dac_code[11], charge_switch, discharge_switch, discharge_allowed,
  // steady_motion, pad
  output logic [15:0]  m_tdata
);

  scpc_pkg::scpc_cfg_t cfg;
  scpc_pkg::scpc_in_t  a_item;
  scpc_pkg::scpc_res_t ctrl_res, b_res;
  logic        a_valid, b_valid, c_valid;
  logic        adv_b, adv_c;
  logic [30:0] prod;
  logic [7:0]  quot;
  logic [10:0] dac_code;
  logic        charge_switch, discharge_switch, discharge_allowed, steady_motion;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_power   <= scpc_pkg::TARGET_POWER_RST;
      cfg.max_voltage_mv <= scpc_pkg::MAX_VOLTAGE_RST;
      cfg.min_voltage_mv <= scpc_pkg::MIN_VOLTAGE_RST;
      cfg.link_timeout   <= scpc_pkg::LINK_TIMEOUT_RST;
      cfg.steady_time    <= scpc_pkg::STEADY_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scpc_pkg::CFG_TARGET_POWER: cfg.target_power   <= cfg_data;
        scpc_pkg::CFG_MAX_VOLTAGE:  cfg.max_voltage_mv <= cfg_data[14:0];
        scpc_pkg::CFG_MIN_VOLTAGE:  cfg.min_voltage_mv <= cfg_data[14:0];
        scpc_pkg::CFG_LINK_TIMEOUT: cfg.link_timeout   <= cfg_data[7:0];
        scpc_pkg::CFG_STEADY_TIME:  cfg.steady_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign adv_c    = b_valid && (!c_valid || m_tready);
  assign adv_b    = a_valid && (!b_valid || adv_c);
  assign s_tready = !a_valid || adv_b;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (s_tready) a_valid <= s_tvalid;
      if (!b_valid || adv_c) b_valid <= adv_b;
      if (!c_valid || m_tready) c_valid <= adv_c;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_item.starting       <= s_tdata[0];
      a_item.link_ok        <= s_tdata[1];
      a_item.remote_mode    <= s_tdata[2];
      a_item.shift_pressed  <= s_tdata[3];
      a_item.chassis_power  <= s_tdata[19:4];
      a_item.remain_energy  <= s_tdata[35:20];
      a_item.speed_target   <= s_tdata[51:36];
      a_item.cap_voltage_mv <= s_tdata[66:52];
      a_item.tick_time      <= s_tdata[98:67];
    end
  end

  scpc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .en   (adv_b),
    .cfg  (cfg),
    .item (a_item),
    .res  (ctrl_res)
  );

  // pi sum register
  always_ff @(posedge clk) begin
    if (adv_b) b_res <= ctrl_res;
  end

  // divide by 75 through the reciprocal
  assign prod = 31'(b_res.quo_in) * 31'(scpc_pkg::DAC_RECIP);
  assign quot = prod[scpc_pkg::DAC_SHIFT +: 8];

  // output register
  always_ff @(posedge clk) begin
    if (adv_c) begin
      dac_code          <= b_res.dac_on ? (scpc_pkg::DAC_BASE + 11'(quot)) : '0;
      charge_switch     <= b_res.charge_switch;
      discharge_switch  <= b_res.discharge_switch;
      discharge_allowed <= b_res.discharge_allowed;
      steady_motion     <= b_res.steady_motion;
    end
  end

  assign m_tvalid = c_valid;
  assign m_tdata  = {1'b0, steady_motion, discharge_allowed, discharge_switch,
                     charge_switch, dac_code};

  `SCPC_ASSERT_IMPLY(a_dac_range, m_tvalid, (dac_code == 11'd0) || ((dac_code >= scpc_pkg::DAC_BASE) && (dac_code <= scpc_pkg::DAC_MAX)), "dac code out of range")
  `SCPC_ASSERT_IMPLY(a_allow_needs_dis, m_tvalid && discharge_allowed, discharge_switch, "discharge allowed while switch off")
  `SCPC_ASSERT_IMPLY(a_charge_has_dac, m_tvalid && charge_switch, dac_code != 11'd0, "charge switch on with zero dac code")
  `SCPC_ASSERT_NEXT(a_stall_holds_b, b_valid && !adv_c, b_valid, "pi stage dropped a beat")

endmodule
